@@ rtl/sha1_message_digest_core_assert.svh @@
// Assertion macros for the SHA-1 core
`ifndef SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA1_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define SHA1_ASSERT(label, clk, rst_n, prop, msg)
`endif
`ifndef SYNTHESIS
`define SHA1_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA1_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps
package sha1_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha1_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha1_out_t;

	// command from front to back
	typedef struct packed {
		logic [1:0]   op;
		logic [511:0] block;
	} sha1_cmd_t;

	localparam logic [1:0] OP_BLOCK = 2'd0;
	localparam logic [1:0] OP_FINAL = 2'd1;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] POS_MASK = 6'h3f;
endpackage

@@ rtl/sha1_message_digest_core.sv @@
`timescale 1ns / 1ps
// SHA-1 core: one byte per word in, five digest words out.
// Bytes are taken one per cycle while in_stall is low; a full block runs 80 rounds,
// one per cycle, in the back-end compression unit, which takes the next block when idle.
// After the closing word one padding block follows, or two if 56 bytes or more are left,
// and the final block is followed by five output words.
// Async active-low reset loads the initial vector and clears the byte count.
module sha1_message_digest_core import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  sha1_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output sha1_out_t out_data
);
	logic      cmd_valid;
	logic      cmd_stall;
	sha1_cmd_t cmd_data;

	sha1_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data)
	);

	sha1_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

@@ rtl/sha1_front.sv @@
`timescale 1ns / 1ps
module sha1_front import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  sha1_in_t  in_data,
	output logic      cmd_valid,
	input  logic      cmd_stall,
	output sha1_cmd_t cmd_data
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_PAD  = 3'b010,
		F_LEN  = 3'b100
	} fstate_t;

	fstate_t      state_q;
	logic [511:0] buf_q;
	logic [60:0]  count_q;
	logic         cmd_valid_q;
	sha1_cmd_t    cmd_q;

	logic [5:0]   pos;
	logic [511:0] buf_w;
	logic [511:0] pad_blk;
	logic [63:0]  bits;

	assign pos = count_q[5:0] & POS_MASK;
	assign bits = {count_q, 3'b000};
	assign in_stall = (state_q != F_IDLE) || cmd_valid_q;
	assign cmd_valid = cmd_valid_q;
	assign cmd_data = cmd_q;

	// insert the byte at its big-endian slot
	always_comb begin
		buf_w = buf_q;
		buf_w[511 - 8 * pos -: 8] = in_data.data_byte;
	end

	// pad from current position: 0x80, zeros after
	always_comb begin
		pad_blk = buf_q;
		for (int i = 0; i < 64; i++) begin
			if (6'(i) == pos) begin
				pad_blk[511 - 8 * i -: 8] = PAD_BYTE;
			end else if (6'(i) > pos) begin
				pad_blk[511 - 8 * i -: 8] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			count_q <= '0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (cmd_valid_q && !cmd_stall) begin
				cmd_valid_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (in_valid && !in_stall) begin
						if (in_data.byte_valid) begin
							buf_q <= buf_w;
							count_q <= count_q + 61'd1;
							if (pos == 6'd63) begin
								cmd_q.op <= OP_BLOCK;
								cmd_q.block <= buf_w;
								cmd_valid_q <= 1'b1;
							end
						end
						if (in_data.end_of_message) begin
							state_q <= F_PAD;
						end
					end
				end
				F_PAD: begin
					if (!cmd_valid_q) begin
						cmd_valid_q <= 1'b1;
						if (pos >= 6'd56) begin
							cmd_q.op <= OP_BLOCK;
							cmd_q.block <= pad_blk;
							buf_q <= '0;
							state_q <= F_LEN;
						end else begin
							cmd_q.op <= OP_FINAL;
							cmd_q.block <= {pad_blk[511:64], bits};
							count_q <= '0;
							state_q <= F_IDLE;
						end
					end
				end
				F_LEN: begin
					if (!cmd_valid_q) begin
						cmd_valid_q <= 1'b1;
						cmd_q.op <= OP_FINAL;
						cmd_q.block <= {448'd0, bits};
						count_q <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/sha1_back.sv @@
`timescale 1ns / 1ps
`include "sha1_message_digest_core_assert.svh"
module sha1_back import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  sha1_cmd_t cmd_data,
	output logic      out_valid,
	input  logic      out_stall,
	output sha1_out_t out_data
);
	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RUN  = 3'b010,
		B_OUT  = 3'b100
	} bstate_t;

	bstate_t     state_q;
	logic [6:0]  round_q;
	logic [2:0]  widx_q;
	logic        final_q;
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];

	logic [31:0] wt, f, k, tmp, wnew;

	assign cmd_stall = (state_q != B_IDLE);
	assign out_valid = (state_q == B_OUT);
	assign out_data.digest_word = h_q[widx_q];
	assign out_data.word_index = widx_q;
	assign out_data.last_word = (widx_q == 3'd4);

	// schedule window: w_q[0] is always word t
	assign wnew = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1
		| ((w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]) >> 31);
	assign wt = w_q[0];

	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + wt + k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			round_q <= '0;
			widx_q <= '0;
			final_q <= 1'b0;
			h_q[0] <= IV0;
			h_q[1] <= IV1;
			h_q[2] <= IV2;
			h_q[3] <= IV3;
			h_q[4] <= IV4;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						for (int i = 0; i < 16; i++) begin
							w_q[i] <= cmd_data.block[511 - 32 * i -: 32];
						end
						a_q <= h_q[0];
						b_q <= h_q[1];
						c_q <= h_q[2];
						d_q <= h_q[3];
						e_q <= h_q[4];
						final_q <= (cmd_data.op == OP_FINAL);
						round_q <= '0;
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					// advance one round, shift the window
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i + 1];
					end
					w_q[15] <= wnew;
					e_q <= d_q;
					d_q <= c_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q;
					a_q <= tmp;
					round_q <= round_q + 7'd1;
					if (round_q == 7'd79) begin
						h_q[0] <= h_q[0] + tmp;
						h_q[1] <= h_q[1] + a_q;
						h_q[2] <= h_q[2] + {b_q[1:0], b_q[31:2]};
						h_q[3] <= h_q[3] + c_q;
						h_q[4] <= h_q[4] + d_q;
						widx_q <= '0;
						state_q <= final_q ? B_OUT : B_IDLE;
					end
				end
				B_OUT: begin
					if (!out_stall) begin
						if (widx_q == 3'd4) begin
							widx_q <= '0;
							h_q[0] <= IV0;
							h_q[1] <= IV1;
							h_q[2] <= IV2;
							h_q[3] <= IV3;
							h_q[4] <= IV4;
							state_q <= B_IDLE;
						end else begin
							widx_q <= widx_q + 3'd1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`SHA1_ASSERT(a_widx, clk, arst_n, out_valid |-> (widx_q <= 3'd4), "word index out of range")
	`SHA1_ASSERT(a_round, clk, arst_n, (state_q == B_RUN) |-> (round_q < 7'd80), "round overrun")
	`SHA1_ASSERT(a_last, clk, arst_n, (out_valid && !out_stall && out_data.last_word) |=> !out_valid, "digest not closed")
endmodule
